[design/uamf_pkg.sv]
// uamf_pkg: shared constants, operation codes and controller states
// for the unit-augment max flow block; no dependencies
package uamf_pkg;

    localparam int MAX_NODES     = 64;
    localparam int NODE_W        = 6;
    localparam int NCOUNT_W      = 7;
    localparam int VALUE_W       = 24;
    localparam int DEF_MAX_EDGES = 256;
    localparam int DEF_CAP_BITS  = 16;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_SOLVE = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_START,
        ST_SCAN,
        ST_DEQ,
        ST_AUG_P,
        ST_AUG_E,
        ST_AUG_W,
        ST_AUG_T,
        ST_FINISH
    } t_state;

endpackage

[design/unit_augment_max_flow.sv]
// add edge, clear, rejected requests: answered in idle; read edge flow: via ST_READ
// solve: a search round scans the edge ram for the source and each dequeued node,
// then reads pred and edge rams and writes the flow per path arc, one unit per path
// one transaction in work at a time; the edge ram port sets the solve time
// reset (synchronous, active low): no edges, total flow 0, node_count 64
// depends on uamf_pkg and uamf_ram
module unit_augment_max_flow #(
    parameter int MAX_EDGES = uamf_pkg::DEF_MAX_EDGES,
    parameter int CAP_BITS  = uamf_pkg::DEF_CAP_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [5:0]  i_from_node,
    input  logic [5:0]  i_to_node,
    input  logic [15:0] i_capacity,
    input  logic [7:0]  i_edge_index,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [23:0] o_value,
    output logic        o_error,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data
);

    localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int EDW = 2 * uamf_pkg::NODE_W + 2 * CAP_BITS;
    localparam int NW  = uamf_pkg::NODE_W;
    localparam int CW  = uamf_pkg::NCOUNT_W;
    localparam int VW  = uamf_pkg::VALUE_W;

    uamf_pkg::t_state r_state, n_state;

    logic [CW-1:0]                r_nc;
    logic [ECW-1:0]               r_edges, n_edges;
    logic [VW-1:0]                r_total, n_total;
    logic                         r_out_valid, n_out_valid;
    logic [VW-1:0]                r_value, n_value;
    logic                         r_error, n_error;
    logic [uamf_pkg::MAX_NODES-1:0] r_reached, n_reached;
    logic [NW-1:0]                r_cur, n_cur;
    logic [NW:0]                  r_qh, n_qh, r_qt, n_qt;
    logic [ECW-1:0]               r_scan, n_scan;
    logic                         r_pend, n_pend;
    logic [EW-1:0]                r_pend_edge, n_pend_edge;
    logic [NW-1:0]                r_v, n_v;
    logic [EW:0]                  r_arc, n_arc;

    logic            in_fire;
    logic            e_we;
    logic [EW-1:0]   e_waddr, e_raddr;
    logic [EDW-1:0]  e_wdata, e_rdata;
    logic [NW-1:0]   q_rdata;
    logic [EW:0]     p_rdata;

    logic [NW-1:0]       e_tail, e_head;
    logic [CAP_BITS-1:0] e_cap, e_flow;
    logic                in_rng, fwd, rev, hit, scan_done, add_err;
    logic [NW-1:0]       tgt, sink, nxt_v;
    logic [CAP_BITS-1:0] new_flow;

    assign e_tail = e_rdata[EDW-1 -: NW];
    assign e_head = e_rdata[EDW-NW-1 -: NW];
    assign e_cap  = e_rdata[2*CAP_BITS-1 -: CAP_BITS];
    assign e_flow = e_rdata[CAP_BITS-1:0];

    assign o_in_ready  = (r_state == uamf_pkg::ST_IDLE) && (!r_out_valid || i_out_ready);
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_error     = r_error;

    assign sink   = NW'(r_nc - CW'(1));
    assign in_rng = (CW'(e_tail) < r_nc) && (CW'(e_head) < r_nc);
    assign fwd    = in_rng && (e_tail == r_cur) && (e_cap > e_flow) && !r_reached[e_head];
    assign rev    = in_rng && !fwd && (e_head == r_cur) && (e_flow != '0)
                    && !r_reached[e_tail];
    assign hit    = (r_state == uamf_pkg::ST_SCAN) && r_pend && (fwd || rev);
    assign tgt    = fwd ? e_head : e_tail;
    assign scan_done = !r_pend && (r_scan == r_edges);
    assign add_err = (r_edges == ECW'(MAX_EDGES)) || (CW'(i_from_node) >= r_nc)
                     || (CW'(i_to_node) >= r_nc);
    assign new_flow = r_arc[0] ? (e_flow - CAP_BITS'(1)) : (e_flow + CAP_BITS'(1));
    assign nxt_v    = r_arc[0] ? e_head : e_tail;

    // edge ram port selection
    always_comb begin
        e_we    = 1'b0;
        e_waddr = EW'(r_edges);
        e_wdata = {i_from_node, i_to_node, CAP_BITS'(i_capacity), CAP_BITS'(0)};
        e_raddr = EW'(i_edge_index);
        case (r_state)
            uamf_pkg::ST_IDLE: begin
                e_we = in_fire && (uamf_pkg::t_op'(i_op) == uamf_pkg::OP_ADD) && !add_err;
            end
            uamf_pkg::ST_SCAN: begin
                e_raddr = EW'(r_scan);
            end
            uamf_pkg::ST_AUG_E: begin
                e_raddr = p_rdata[EW:1];
            end
            uamf_pkg::ST_AUG_W: begin
                e_we    = 1'b1;
                e_waddr = r_arc[EW:1];
                e_wdata = {e_tail, e_head, e_cap, new_flow};
            end
            default: begin
            end
        endcase
    end

    uamf_ram #(.WIDTH(EDW), .DEPTH(MAX_EDGES)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_raddr (e_raddr),
        .o_rdata (e_rdata)
    );

    uamf_ram #(.WIDTH(NW), .DEPTH(uamf_pkg::MAX_NODES)) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (hit),
        .i_waddr (r_qt[NW-1:0]),
        .i_wdata (tgt),
        .i_raddr (r_qh[NW-1:0]),
        .o_rdata (q_rdata)
    );

    uamf_ram #(.WIDTH(EW + 1), .DEPTH(uamf_pkg::MAX_NODES)) u_pred_ram (
        .i_clk   (i_clk),
        .i_we    (hit),
        .i_waddr (tgt),
        .i_wdata ({r_pend_edge, !fwd}),
        .i_raddr (r_v),
        .o_rdata (p_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            uamf_pkg::ST_IDLE: begin
                if (in_fire) begin
                    case (uamf_pkg::t_op'(i_op))
                        uamf_pkg::OP_SOLVE: n_state = uamf_pkg::ST_START;
                        uamf_pkg::OP_READ: begin
                            if (32'(i_edge_index) < 32'(r_edges)) begin
                                n_state = uamf_pkg::ST_READ;
                            end
                        end
                        default: n_state = uamf_pkg::ST_IDLE;
                    endcase
                end
            end
            uamf_pkg::ST_READ:  n_state = uamf_pkg::ST_IDLE;
            uamf_pkg::ST_START: n_state = uamf_pkg::ST_SCAN;
            uamf_pkg::ST_SCAN: begin
                if (hit && tgt == sink) begin
                    n_state = uamf_pkg::ST_AUG_P;
                end else if (scan_done) begin
                    n_state = (r_qh == r_qt) ? uamf_pkg::ST_FINISH : uamf_pkg::ST_DEQ;
                end
            end
            uamf_pkg::ST_DEQ:   n_state = uamf_pkg::ST_SCAN;
            uamf_pkg::ST_AUG_P: n_state = uamf_pkg::ST_AUG_E;
            uamf_pkg::ST_AUG_E: n_state = uamf_pkg::ST_AUG_W;
            uamf_pkg::ST_AUG_W: begin
                n_state = (nxt_v == '0) ? uamf_pkg::ST_AUG_T : uamf_pkg::ST_AUG_P;
            end
            uamf_pkg::ST_AUG_T: n_state = uamf_pkg::ST_START;
            uamf_pkg::ST_FINISH: n_state = uamf_pkg::ST_IDLE;
            default: n_state = uamf_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_edges     = r_edges;
        n_total     = r_total;
        n_out_valid = r_out_valid && !i_out_ready;
        n_value     = r_value;
        n_error     = r_error;
        n_reached   = r_reached;
        n_cur       = r_cur;
        n_qh        = r_qh;
        n_qt        = r_qt;
        n_scan      = r_scan;
        n_pend      = r_pend;
        n_pend_edge = r_pend_edge;
        n_v         = r_v;
        n_arc       = r_arc;
        case (r_state)
            uamf_pkg::ST_IDLE: begin
                if (in_fire) begin
                    case (uamf_pkg::t_op'(i_op))
                        uamf_pkg::OP_ADD: begin
                            n_out_valid = 1'b1;
                            n_error     = add_err;
                            n_value     = add_err ? '0 : VW'(r_edges);
                            if (!add_err) begin
                                n_edges = r_edges + ECW'(1);
                            end
                        end
                        uamf_pkg::OP_READ: begin
                            if (32'(i_edge_index) >= 32'(r_edges)) begin
                                n_out_valid = 1'b1;
                                n_error     = 1'b1;
                                n_value     = '0;
                            end
                        end
                        uamf_pkg::OP_CLEAR: begin
                            n_edges     = '0;
                            n_total     = '0;
                            n_out_valid = 1'b1;
                            n_error     = 1'b0;
                            n_value     = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            uamf_pkg::ST_READ: begin
                n_out_valid = 1'b1;
                n_error     = 1'b0;
                n_value     = VW'(e_flow);
            end
            uamf_pkg::ST_START: begin
                n_reached = {{(uamf_pkg::MAX_NODES-1){1'b0}}, 1'b1};
                n_cur     = '0;
                n_qh      = (NW+1)'(1);
                n_qt      = (NW+1)'(1);
                n_scan    = '0;
                n_pend    = 1'b0;
            end
            uamf_pkg::ST_SCAN: begin
                n_pend      = (r_scan != r_edges);
                n_pend_edge = EW'(r_scan);
                if (r_scan != r_edges) begin
                    n_scan = r_scan + ECW'(1);
                end
                if (hit) begin
                    n_reached[tgt] = 1'b1;
                    n_qt           = r_qt + (NW+1)'(1);
                    n_v            = tgt;
                end
                if (scan_done && r_qh != r_qt) begin
                    n_qh = r_qh + (NW+1)'(1);
                end
            end
            uamf_pkg::ST_DEQ: begin
                n_cur  = q_rdata;
                n_scan = '0;
                n_pend = 1'b0;
            end
            uamf_pkg::ST_AUG_E: begin
                n_arc = p_rdata;
            end
            uamf_pkg::ST_AUG_W: begin
                n_v = nxt_v;
            end
            uamf_pkg::ST_AUG_T: begin
                if (r_total != {VW{1'b1}}) begin
                    n_total = r_total + VW'(1);
                end
            end
            uamf_pkg::ST_FINISH: begin
                n_out_valid = 1'b1;
                n_error     = 1'b0;
                n_value     = r_total;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= uamf_pkg::ST_IDLE;
            r_nc        <= CW'(uamf_pkg::MAX_NODES);
            r_edges     <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_edges     <= n_edges;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
            if (i_cfg_valid) begin
                if (i_cfg_data < CW'(2)) begin
                    r_nc <= CW'(2);
                end else if (i_cfg_data > CW'(uamf_pkg::MAX_NODES)) begin
                    r_nc <= CW'(uamf_pkg::MAX_NODES);
                end else begin
                    r_nc <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value     <= n_value;
        r_error     <= n_error;
        r_reached   <= n_reached;
        r_cur       <= n_cur;
        r_qh        <= n_qh;
        r_qt        <= n_qt;
        r_scan      <= n_scan;
        r_pend_edge <= n_pend_edge;
        r_v         <= n_v;
        r_arc       <= n_arc;
    end

endmodule

[design/uamf_ram.sv]
// uamf_ram: generic single-write, single-read ram with registered read data
// no dependencies
module uamf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
